>>> rtl/core/poc_pkg.sv
`default_nettype none

package poc_pkg;

  // Pattern bytes held by the two 64-bit pattern registers
  localparam int REG_BYTES = 16;
  localparam int MAX_PATTERN_DEFAULT = 16;

  localparam int LEN_W = 5;
  localparam int COUNT_W = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef logic [7:0] byte_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [REG_BYTES*8-1:0] pattern_t;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

endpackage

`default_nettype wire

>>> rtl/core/poc_if.sv
`default_nettype none

interface poc_in_if;
  logic              valid;
  logic              ready;
  poc_pkg::byte_t    text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface poc_out_if;
  logic              valid;
  logic              ready;
  logic              match_here;
  poc_pkg::count_t   match_count;
  logic              count_final;

  modport source (output valid, output match_here, output match_count,
                  output count_final, input ready);
  modport sink (input valid, input match_here, input match_count,
                input count_final, output ready);
endinterface

`default_nettype wire

>>> rtl/core/poc_cell.sv
`default_nettype none

// One window position: holds a text byte and its valid bit, passes both on
// to the next position on every shift, and checks its byte against the
// pattern byte that lines up with it.
module poc_cell #(
  parameter int POS = 0
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   shift,
  input  wire poc_pkg::byte_t   byte_in,
  input  wire                   valid_in,
  input  wire poc_pkg::pattern_t pattern,
  input  wire poc_pkg::len_t    len,
  output poc_pkg::byte_t        byte_out,
  output logic                  valid_out,
  output logic                  ok
);

  poc_pkg::byte_t data;
  logic           valid;
  logic           used;
  logic [5:0]     diff;
  logic [3:0]     idx;
  poc_pkg::byte_t pbyte;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= byte_in;
    end
  end

  // pattern byte len-1-POS sits at this position
  always_comb begin
    used  = (32'(POS) < 32'(len));
    diff  = {1'b0, len} - 6'(POS + 1);
    idx   = diff[3:0];
    pbyte = pattern[idx*8 +: 8];
    ok    = !used || (valid && (data == pbyte));
  end

  assign byte_out  = data;
  assign valid_out = valid;

endmodule

`default_nettype wire

>>> rtl/core/pattern_occurrence_counter_unit.sv
`default_nettype none

// Channel   Dir  Payload                                   Handshake
// text      in   text_byte[7:0], end_of_text               valid/ready
// result    out  match_here, match_count[31:0], count_final valid/ready
// config    in   write_index[1:0], write_data[63:0]        write_enable only
//
// One byte per cycle sustained while the result side does not stall; a
// request shifts into the window (cell 0, s1) when it is accepted, and its
// result is then registered in the output stage (compare and count).
// The window is a chain of MAX_PATTERN cells shifting one position per
// accepted byte; all positions compare in parallel in the cycle after.
// rst is synchronous: clears cell valid bits, the count and the output stage;
// pattern registers return to zero and the length to 1.
// A stalled result holds in the output register while the next byte still
// enters the window; text.ready drops only when both stages are full.
module pattern_occurrence_counter_unit #(
  parameter int MAX_PATTERN = poc_pkg::MAX_PATTERN_DEFAULT
) (
  input  wire                               clk,
  input  wire                               rst,
  poc_in_if.sink                            text,
  poc_out_if.source                         result,
  input  wire                               write_enable,
  input  wire [poc_pkg::CFG_INDEX_W-1:0]    write_index,
  input  wire [poc_pkg::CFG_DATA_W-1:0]     write_data
);

  // longest pattern the window and the registers can both hold
  localparam int LIM = (MAX_PATTERN < poc_pkg::REG_BYTES) ? MAX_PATTERN : poc_pkg::REG_BYTES;

  // ---------------- configuration registers ----------------
  logic [poc_pkg::CFG_DATA_W-1:0] pattern_low;
  logic [poc_pkg::CFG_DATA_W-1:0] pattern_high;
  poc_pkg::len_t                  pattern_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= poc_pkg::len_t'(1);
    end else if (write_enable) begin
      unique case (write_index)
        poc_pkg::REG_PATTERN_LOW:    pattern_low    <= write_data;
        poc_pkg::REG_PATTERN_HIGH:   pattern_high   <= write_data;
        poc_pkg::REG_PATTERN_LENGTH: pattern_length <= write_data[poc_pkg::LEN_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  poc_pkg::pattern_t pattern;
  poc_pkg::len_t     len_eff;

  assign pattern = {pattern_high, pattern_low};
  assign len_eff = (pattern_length > poc_pkg::len_t'(LIM)) ? poc_pkg::len_t'(LIM)
                                                            : pattern_length;

  // ---------------- handshake ----------------
  // s1: the newest byte sits in cell 0 and waits for compare/count
  logic s1_valid;
  logic s1_last;
  logic accept;
  logic adv2;

  assign adv2        = s1_valid && (!result.valid || result.ready);
  assign text.ready  = !s1_valid || adv2;
  assign accept      = text.valid && text.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        s1_last  <= text.end_of_text;
      end else if (adv2) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // ---------------- window: chain of cells ----------------
  // Valid bits behind cell 0 are dropped when the byte in cell 0 closed
  // the previous text, so a new text starts with an empty window.
  poc_pkg::byte_t cell_byte [MAX_PATTERN];
  logic           cell_valid [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_ok;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    poc_pkg::byte_t byte_in;
    logic           valid_in;

    if (k == 0) begin : g_head
      assign byte_in  = text.text_byte;
      assign valid_in = 1'b1;
    end else begin : g_body
      assign byte_in  = cell_byte[k-1];
      assign valid_in = cell_valid[k-1] && !s1_last;
    end

    poc_cell #(
      .POS (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (accept),
      .byte_in   (byte_in),
      .valid_in  (valid_in),
      .pattern   (pattern),
      .len       (len_eff),
      .byte_out  (cell_byte[k]),
      .valid_out (cell_valid[k]),
      .ok        (cell_ok[k])
    );
  end

  // ---------------- compare and count ----------------
  logic            hit;
  poc_pkg::count_t occurrences;
  poc_pkg::count_t count_new;

  assign hit       = (len_eff != '0) && (&cell_ok);
  assign count_new = occurrences +
                     poc_pkg::count_t'(hit && (occurrences != poc_pkg::COUNT_MAX));

  always_ff @(posedge clk) begin
    if (rst) begin
      occurrences <= '0;
    end else if (adv2) begin
      occurrences <= s1_last ? '0 : count_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv2) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      result.match_here  <= hit;
      result.match_count <= count_new;
      result.count_final <= s1_last;
    end
  end

`ifndef SYNTHESIS
  a_hit_counts: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.match_here |-> result.match_count != '0)
    else $error("match reported with zero count");

  a_text_clears: assert property (@(posedge clk) disable iff (rst)
    adv2 && s1_last |=> occurrences == '0)
    else $error("count not cleared after end of text");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> cell_valid[0])
    else $error("pending byte without a valid window head");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && result.valid && !result.ready |-> !text.ready)
    else $error("input taken while both stages are full");
`endif

endmodule

`default_nettype wire

>>> tb/pattern_occurrence_checker.sv
`default_nettype none

// Watches the text and result channels and the register port, keeps its own
// copy of the window and count, and compares every result in order.
module pattern_occurrence_checker #(
  parameter int MAX_PATTERN = poc_pkg::MAX_PATTERN_DEFAULT
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  input  wire                            in_ready,
  input  wire [7:0]                      in_byte,
  input  wire                            in_last,
  input  wire                            out_valid,
  input  wire                            out_ready,
  input  wire                            out_hit,
  input  wire [poc_pkg::COUNT_W-1:0]     out_count,
  input  wire                            out_final,
  input  wire                            write_enable,
  input  wire [poc_pkg::CFG_INDEX_W-1:0] write_index,
  input  wire [poc_pkg::CFG_DATA_W-1:0]  write_data,
  output int                             pending,
  output int                             fail_count,
  output int                             results_seen,
  output int                             hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SPAN_LIMIT = (MAX_PATTERN < poc_pkg::REG_BYTES) ? MAX_PATTERN
                                                                 : poc_pkg::REG_BYTES;

  typedef struct packed {
    logic            hit;
    poc_pkg::count_t count;
    logic            closes_text;
  } occurrence_t;

  occurrence_t awaited_occurrences[$];

  logic [poc_pkg::CFG_DATA_W-1:0] pat_low;
  logic [poc_pkg::CFG_DATA_W-1:0] pat_high;
  poc_pkg::len_t                  pat_len;
  poc_pkg::byte_t                 window[MAX_PATTERN];
  int                             fill;
  poc_pkg::count_t                occurrences;

  function automatic void clear_text();
    for (int k = 0; k < MAX_PATTERN; k++) window[k] = '0;
    fill = 0;
    occurrences = '0;
  endfunction

  // shift one byte in and work out whether an occurrence ends on it
  function automatic occurrence_t scan_byte(poc_pkg::byte_t b, logic last);
    occurrence_t       r;
    poc_pkg::pattern_t pat;
    int                span;
    logic              hit;
    pat = {pat_high, pat_low};
    span = (int'(pat_len) > SPAN_LIMIT) ? SPAN_LIMIT : int'(pat_len);
    for (int k = MAX_PATTERN - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = b;
    if (fill < MAX_PATTERN) fill++;
    hit = (span > 0) && (fill >= span);
    // pattern byte k lies span-1-k places back from the newest byte
    for (int k = 0; k < span; k++)
      if (window[span-1-k] != pat[8*k +: 8]) hit = 1'b0;
    if (hit && occurrences != poc_pkg::COUNT_MAX) occurrences++;
    r.hit = hit;
    r.count = occurrences;
    r.closes_text = last;
    if (last) clear_text();
    return r;
  endfunction

  always @(posedge clk) begin
    occurrence_t want;
    if (rst) begin
      awaited_occurrences.delete();
      pat_low = '0;
      pat_high = '0;
      pat_len = poc_pkg::len_t'(1);
      clear_text();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_hit) hits_seen++;
        if (awaited_occurrences.size() == 0) begin
          $error("result with nothing awaited: match_here %0b match_count %0d",
                 out_hit, out_count);
          fail_count++;
        end else begin
          want = awaited_occurrences.pop_front();
          if (out_hit !== want.hit) begin
            $error("match_here: expected %0b, got %0b", want.hit, out_hit);
            fail_count++;
          end
          if (out_count !== want.count) begin
            $error("match_count: expected %0d, got %0d", want.count, out_count);
            fail_count++;
          end
          if (out_final !== want.closes_text) begin
            $error("count_final: expected %0b, got %0b", want.closes_text, out_final);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        awaited_occurrences.push_back(scan_byte(in_byte, in_last));
      if (write_enable) begin
        case (write_index)
          poc_pkg::REG_PATTERN_LOW: begin
            pat_low = write_data;
          end
          poc_pkg::REG_PATTERN_HIGH: begin
            pat_high = write_data;
          end
          poc_pkg::REG_PATTERN_LENGTH: begin
            pat_len = write_data[poc_pkg::LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
      pending <= awaited_occurrences.size();
    end
  end

endmodule

`default_nettype wire

>>> tb/pattern_occurrence_counter_unit_test.sv
`default_nettype none

// Stimulus and verdict for the pattern occurrence counter. The checker beside
// the block does all prediction; this module only feeds text, programs the
// pattern and throttles the result side.
module pattern_occurrence_counter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // index past the last register; writes there must change nothing
  localparam logic [poc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 146;
  // keep a wide margin over the slowest run
  localparam int CYCLE_LIMIT = 300000;

  logic                            clk;
  logic                            rst;
  logic                            write_enable;
  logic [poc_pkg::CFG_INDEX_W-1:0] write_index;
  logic [poc_pkg::CFG_DATA_W-1:0]  write_data;

  poc_in_if  text_if();
  poc_out_if result_if();

  // stimulus-side copy of the pattern, used only to plant occurrences
  poc_pkg::pattern_t cur_pattern;
  poc_pkg::len_t     cur_len;

  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;
  int texts_closed;
  int cycle_count;

  int pending;
  int fail_count;
  int results_seen;
  int hits_seen;

  pattern_occurrence_counter_unit uut (
    .clk          (clk),
    .rst          (rst),
    .text         (text_if),
    .result       (result_if),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  pattern_occurrence_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (text_if.valid),
    .in_ready     (text_if.ready),
    .in_byte      (text_if.text_byte),
    .in_last      (text_if.end_of_text),
    .out_valid    (result_if.valid),
    .out_ready    (result_if.ready),
    .out_hit      (result_if.match_here),
    .out_count    (result_if.match_count),
    .out_final    (result_if.count_final),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .pending      (pending),
    .fail_count   (fail_count),
    .results_seen (results_seen),
    .hits_seen    (hits_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: ready is redrawn every cycle from the current stall rate.
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One text request. Random idle cycles go before it; valid stays high
  // from one request to the next when no gap is drawn.
  task automatic send_request(input poc_pkg::byte_t b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      text_if.valid <= 1'b0;
      @(posedge clk);
    end
    text_if.valid <= 1'b1;
    text_if.text_byte <= b;
    text_if.end_of_text <= last;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    items_sent++;
    if (last) texts_closed++;
  endtask

  // Stop sending and wait until the checker has every result back. The
  // first edge lets a request accepted on this very edge show up in pending.
  task automatic wait_drained();
    text_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write both pattern words and the length; only legal while drained.
  // The length word sometimes carries junk above the length field, and a
  // write to the unused index is slipped in ahead of the length.
  task automatic program_pattern(input poc_pkg::pattern_t pat, input poc_pkg::len_t len);
    logic [poc_pkg::CFG_DATA_W-1:0] len_word;
    len_word = {$urandom(), $urandom()};
    if ($urandom_range(1) == 0) len_word = '0;
    len_word[poc_pkg::LEN_W-1:0] = len;
    write_enable <= 1'b1;
    write_index <= poc_pkg::REG_PATTERN_LOW;
    write_data <= pat[poc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    write_index <= poc_pkg::REG_PATTERN_HIGH;
    write_data <= pat[2*poc_pkg::CFG_DATA_W-1:poc_pkg::CFG_DATA_W];
    @(posedge clk);
    if ($urandom_range(3) == 0) begin
      write_index <= REG_UNUSED;
      write_data <= {$urandom(), $urandom()};
      @(posedge clk);
    end
    write_index <= poc_pkg::REG_PATTERN_LENGTH;
    write_data <= len_word;
    @(posedge clk);
    write_enable <= 1'b0;
    cur_pattern = pat;
    cur_len = len;
  endtask

  // Pattern with period 1..3 (overlapping hits) or fully random bytes.
  function automatic poc_pkg::pattern_t make_pattern(int period);
    poc_pkg::pattern_t pat;
    poc_pkg::byte_t    base[3];
    for (int k = 0; k < 3; k++) base[k] = poc_pkg::byte_t'($urandom_range(255));
    for (int k = 0; k < poc_pkg::REG_BYTES; k++)
      pat[8*k +: 8] = (period <= 3) ? base[k % period]
                                    : poc_pkg::byte_t'($urandom_range(255));
    return pat;
  endfunction

  // Random text byte: ends the text now and then, and once in a while the
  // sender holds off until everything is back.
  task automatic put_text_byte(input poc_pkg::byte_t b);
    send_request(b, $urandom_range(99) < 3);
    if ($urandom_range(149) == 0) wait_drained();
  endtask

  // Mostly planted copies of the pattern (some with one corrupted byte),
  // mixed with loose bytes drawn from the pattern or the full byte range.
  task automatic stream_text(input int n_items);
    int             sent;
    int             span;
    int             flaw;
    poc_pkg::byte_t b;
    sent = 0;
    span = (cur_len == 0) ? 4 : ((int'(cur_len) > poc_pkg::REG_BYTES) ? poc_pkg::REG_BYTES
                                                                      : int'(cur_len));
    while (sent < n_items) begin
      if ($urandom_range(99) < 40) begin
        flaw = ($urandom_range(7) == 0) ? int'($urandom_range(span - 1)) : -1;
        for (int k = 0; k < span && sent < n_items; k++) begin
          b = cur_pattern[8*k +: 8];
          if (k == flaw) b = b ^ poc_pkg::byte_t'($urandom_range(1, 255));
          put_text_byte(b);
          sent++;
        end
      end else begin
        if ($urandom_range(1) == 0)
          b = cur_pattern[8*$urandom_range(span - 1) +: 8];
        else
          b = poc_pkg::byte_t'($urandom_range(255));
        put_text_byte(b);
        sent++;
      end
    end
  endtask

  initial begin
    int            period;
    poc_pkg::len_t len;

    rst <= 1'b1;
    write_enable <= 1'b0;
    write_index <= '0;
    write_data <= '0;
    text_if.valid <= 1'b0;
    text_if.text_byte <= '0;
    text_if.end_of_text <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    texts_closed = 0;
    cur_pattern = '0;
    cur_len = poc_pkg::len_t'(1);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed part ---
    // Reset pattern: a single zero byte. The cleared window holds zeros too,
    // but nothing may match before a byte has actually arrived.
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'h00, 1'b1);
    wait_drained();

    // Length zero never matches, even on a zero pattern and zero text.
    program_pattern('0, poc_pkg::len_t'(0));
    send_request(8'h00, 1'b0);
    send_request(8'h00, 1'b1);
    wait_drained();

    // Two-byte pattern: overlapping hits within one text.
    program_pattern(poc_pkg::pattern_t'(16'hA5A5), poc_pkg::len_t'(2));
    send_request(8'hA5, 1'b0);
    send_request(8'hA5, 1'b0);
    send_request(8'hA5, 1'b0);
    send_request(8'h5A, 1'b1);
    wait_drained();

    // Reconfigure mid-text: the window survives, the new pattern applies
    // from the next byte and can match across the change.
    program_pattern(poc_pkg::pattern_t'(8'h5A), poc_pkg::len_t'(1));
    send_request(8'h5A, 1'b0);
    wait_drained();
    program_pattern(poc_pkg::pattern_t'(16'h5A5A), poc_pkg::len_t'(2));
    send_request(8'h5A, 1'b1);
    wait_drained();

    // After end-of-text the window is zero again but must not count as text.
    program_pattern('0, poc_pkg::len_t'(2));
    send_request(8'h00, 1'b0);
    send_request(8'h00, 1'b1);
    wait_drained();

    // --- random phases ---
    // Idle modes rotate: none, sender gaps, receiver stalls, light both.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct = 10;
          recv_stall_pct = 10;
        end
      endcase
      // first phases pin the length extremes: full, over-range, zero, one
      case (phase)
        0: len = poc_pkg::len_t'(poc_pkg::REG_BYTES);
        1: len = '1;
        2: len = poc_pkg::len_t'(0);
        3: len = poc_pkg::len_t'(1);
        4: len = poc_pkg::len_t'(poc_pkg::REG_BYTES + 1);
        default: len = poc_pkg::len_t'($urandom_range(1, poc_pkg::REG_BYTES));
      endcase
      period = $urandom_range(1, 4);
      if (phase == 0) program_pattern('1, len);
      else if (phase == 2) program_pattern('0, len);
      else program_pattern(make_pattern(period), len);
      stream_text(PHASE_ITEMS);
      // half the time close the text; otherwise the next pattern lands mid-text
      if ($urandom_range(1) == 0)
        send_request(poc_pkg::byte_t'($urandom_range(255)), 1'b1);
      wait_drained();
    end

    // settle: a stray late result would still be flagged by the checker
    repeat (8) @(posedge clk);

    $display("Covered %0d text requests in %0d texts over %0d random phases,",
             items_sent, texts_closed, PHASES);
    $display("%0d results compared, %0d of them with a match; %0d mismatches.",
             results_seen, hits_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/poc_pkg.sv
rtl/core/poc_if.sv
rtl/core/poc_cell.sv
rtl/core/pattern_occurrence_counter_unit.sv
tb/pattern_occurrence_checker.sv
tb/pattern_occurrence_counter_unit_test.sv
